[sv/csq_pkg.sv]
`timescale 1ns / 1ps

package csq_pkg;

  localparam int unsigned StepCountDefault = 16;
  localparam int unsigned CfgIndexW        = 3;
  localparam int unsigned CfgDataW         = 64;
  localparam int unsigned LevelW           = 8;
  localparam logic [LevelW-1:0] LevelMax   = 8'd240;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_START_GATE  = 3'd0,
    CFG_BUS_THREE   = 3'd1,
    CFG_DUAL_EIGHT  = 3'd2,
    CFG_RANDOM      = 3'd3,
    CFG_GATE_ASSIGN = 3'd4,
    CFG_LEVELS_LO   = 3'd5,
    CFG_LEVELS_HI   = 3'd6
  } cfg_idx_e;

  // what bus three does to the step
  localparam logic [1:0] BusThreeReset = 2'd0;
  localparam logic [1:0] BusThreeNone  = 2'd1;
  localparam logic [1:0] BusThreeSkip  = 2'd2;

  typedef enum logic [1:0] {
    BUS_ONE   = 2'd0,
    BUS_TWO   = 2'd1,
    BUS_THREE = 2'd2
  } bus_e;

  typedef struct packed {
    logic        start_gate_mode;
    logic [1:0]  bus_three_action;
    logic        dual_eight_mode;
    logic        random_order;
    logic [31:0] gate_assign;
    logic [63:0] step_levels_low;
    logic [63:0] step_levels_high;
  } cfg_t;

  typedef struct packed {
    logic        toggle_level;
    logic        start_level;
    logic        stop_level;
    logic        skip_level;
    logic        reset_level;
    logic [31:0] phase_step;
    logic [16:0] pulse_width;
    logic [3:0]  random_step;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        gate_buses;
    logic              clocked_gate_one;
    logic              clock_out;
    logic              first_step;
    logic [3:0]        step_a;
    logic [3:0]        step_b;
    logic [LevelW-1:0] level_a;
    logic [LevelW-1:0] level_b;
    logic [4:0]        semitone_a;
    logic [4:0]        semitone_b;
    logic              is_running;
  } out_item_t;

endpackage

[sv/csq_cfg.sv]
`timescale 1ns / 1ps

module csq_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [csq_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [csq_pkg::CfgDataW-1:0]       cfg_data_i,
  output csq_pkg::cfg_t                      cfg_o
);
  import csq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_GATE:  cfg_d.start_gate_mode  = cfg_data_i[0];
        CFG_BUS_THREE:   cfg_d.bus_three_action = cfg_data_i[1:0];
        CFG_DUAL_EIGHT:  cfg_d.dual_eight_mode  = cfg_data_i[0];
        CFG_RANDOM:      cfg_d.random_order     = cfg_data_i[0];
        CFG_GATE_ASSIGN: cfg_d.gate_assign      = cfg_data_i[31:0];
        CFG_LEVELS_LO:   cfg_d.step_levels_low  = cfg_data_i;
        CFG_LEVELS_HI:   cfg_d.step_levels_high = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_gate_mode  <= 1'b0;
      cfg_q.bus_three_action <= BusThreeNone;
      cfg_q.dual_eight_mode  <= 1'b0;
      cfg_q.random_order     <= 1'b0;
      cfg_q.gate_assign      <= 32'h5555_5555;
      cfg_q.step_levels_low  <= 64'h7878_7878_7878_7878;
      cfg_q.step_levels_high <= 64'h7878_7878_7878_7878;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/csq_core.sv]
`timescale 1ns / 1ps

module csq_core #(
  parameter int unsigned StepCount = csq_pkg::StepCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  csq_pkg::cfg_t        cfg_i,
  input  csq_pkg::in_item_t    item_i,
  output csq_pkg::out_item_t   result_o
);
  import csq_pkg::*;

  localparam int unsigned IdxW     = $clog2(StepCount);
  localparam int unsigned IdxDepth = 1 << IdxW;
  localparam int unsigned Half     = StepCount / 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(StepCount - 1);
  localparam logic [IdxW-1:0] HalfIdx = IdxW'(Half);

  logic            run_q, run_d;
  logic [31:0]     phase_q, phase_d;
  logic [IdxW-1:0] step_q, step_d;
  logic            held_q, held_d;
  logic [4:0]      hist_q, hist_d;

  logic [IdxW-1:0] rnd_tab  [16];
  logic [IdxW-1:0] half_tab [IdxDepth];

  logic [32:0]     sum;
  logic            clk_bit;
  logic [IdxW-1:0] rnd_wrap;
  logic [IdxW-1:0] step1, step2, step3;
  logic [IdxW-1:0] ia, ib;
  logic [IdxW+3:0] ia_ext, ib_ext;
  logic [1:0]      sw;
  bus_e            bus;
  logic            skip_edge, reset_edge;
  logic [127:0]    levels;
  logic [7:0]      byte_a, byte_b, lvl_a, lvl_b;
  logic [15:0]     prod_a, prod_b;

  // constant wrap tables for the random step and the dual-mode half index
  for (genvar g = 0; g < 16; g++) begin : g_rnd
    assign rnd_tab[g] = IdxW'(g % StepCount);
  end
  for (genvar g = 0; g < IdxDepth; g++) begin : g_half
    assign half_tab[g] = IdxW'(g % Half);
  end

  function automatic logic [IdxW-1:0] step_inc(input logic [IdxW-1:0] s);
    return (s >= LastIdx) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [7:0] sat_level(input logic [7:0] v);
    return (v > LevelMax) ? LevelMax : v;
  endfunction

  assign rnd_wrap = rnd_tab[item_i.random_step];

  always_comb begin
    hist_d  = hist_q;
    run_d   = run_q;
    phase_d = phase_q;
    held_d  = held_q;
    clk_bit = 1'b0;

    // start logic
    if (cfg_i.start_gate_mode) begin
      run_d = item_i.stop_level ? 1'b0 : (item_i.toggle_level | item_i.start_level);
    end else begin
      if (item_i.toggle_level && !hist_q[0]) run_d = ~run_d;
      if (item_i.start_level && !hist_q[1]) run_d = 1'b1;
      if (item_i.stop_level && !hist_q[2]) run_d = 1'b0;
      hist_d[2:0] = {item_i.stop_level, item_i.start_level, item_i.toggle_level};
    end

    // phase accumulator, carry advances the step
    sum   = {1'b0, phase_q} + {1'b0, item_i.phase_step};
    step1 = step_q;
    if (run_d) begin
      if (sum[32]) begin
        step1   = cfg_i.random_order ? rnd_wrap : step_inc(step_q);
        phase_d = '0;
      end else begin
        phase_d = sum[31:0];
      end
      held_d  = {1'b0, phase_d} < {item_i.pulse_width, 16'h0000};
      clk_bit = held_d;
    end
  end

  assign ia = cfg_i.dual_eight_mode ? half_tab[step1] : step1;
  assign ib = cfg_i.dual_eight_mode ? ia + HalfIdx : step1;
  assign ia_ext = {4'b0000, ia};
  assign ib_ext = {4'b0000, ib};

  always_comb begin
    sw = cfg_i.gate_assign[{ia_ext[3:0], 1'b0} +: 2];
    case (sw)
      2'd0:    bus = BUS_THREE;
      2'd1:    bus = BUS_TWO;
      default: bus = BUS_ONE;
    endcase
  end

  assign skip_edge  = item_i.skip_level & ~hist_q[3];
  assign reset_edge = item_i.reset_level & ~hist_q[4];

  always_comb begin
    step2 = skip_edge ? (cfg_i.random_order ? rnd_wrap : step_inc(step1)) : step1;
    step3 = step2;
    if (cfg_i.bus_three_action == BusThreeSkip && bus == BUS_THREE) begin
      step3 = cfg_i.random_order ? rnd_wrap : step_inc(step2);
    end
    step_d = step3;
    if (reset_edge || (cfg_i.bus_three_action == BusThreeReset && bus == BUS_THREE)) begin
      step_d = '0;
    end
  end

  assign levels = {cfg_i.step_levels_high, cfg_i.step_levels_low};
  assign byte_a = levels[{ia_ext[3:0], 3'b000} +: 8];
  assign byte_b = levels[{ib_ext[3:0], 3'b000} +: 8];
  assign lvl_a  = sat_level(byte_a);
  assign lvl_b  = sat_level(byte_b);
  // divide by ten as multiply by 205 / 2048, exact up to 240
  assign prod_a = {8'h00, lvl_a} * 16'd205;
  assign prod_b = {8'h00, lvl_b} * 16'd205;

  always_comb begin
    result_o.gate_buses       = 3'b001 << bus;
    result_o.clocked_gate_one = (bus == BUS_ONE) & held_d;
    result_o.clock_out        = clk_bit;
    result_o.first_step       = (ia == '0);
    result_o.step_a           = ia_ext[3:0];
    result_o.step_b           = ib_ext[3:0];
    result_o.level_a          = lvl_a;
    result_o.level_b          = lvl_b;
    result_o.semitone_a       = prod_a[15:11];
    result_o.semitone_b       = prod_b[15:11];
    result_o.is_running       = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b1;
      phase_q <= '0;
      step_q  <= '0;
      held_q  <= 1'b1;
      hist_q  <= 5'h1f;
    end else if (step_en_i) begin
      run_q   <= run_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      held_q  <= held_d;
      hist_q  <= {item_i.reset_level, item_i.skip_level, hist_d[2:0]};
    end
  end

endmodule

[sv/clocked_step_sequencer.sv]
`timescale 1ns / 1ps

// Step sequencer that takes one sample tick per request and returns one result
// per request. A request goes into an input register, its start logic, phase
// accumulator and step update are worked out in one pass, and the result lands
// in an output register when that register is empty or being drained. While the
// result side keeps draining, a new request can be taken on every clock. While a
// finished result is stalled, one more request can wait in the input register and
// any request after it is stalled. The run flag, phase, step and edge history are
// updated when the result register loads. Configuration writes are never held
// off (cfg_ready_o is always high) and should only be issued while the block is
// idle.
module clocked_step_sequencer #(
  parameter int unsigned STEP_COUNT = csq_pkg::StepCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        toggle_level_i,
  input  logic        start_level_i,
  input  logic        stop_level_i,
  input  logic        skip_level_i,
  input  logic        reset_level_i,
  input  logic [31:0] phase_step_i,
  input  logic [16:0] pulse_width_i,
  input  logic [3:0]  random_step_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  gate_buses_o,
  output logic        clocked_gate_one_o,
  output logic        clock_out_o,
  output logic        first_step_o,
  output logic [3:0]  step_a_o,
  output logic [3:0]  step_b_o,
  output logic [7:0]  level_a_o,
  output logic [7:0]  level_b_o,
  output logic [4:0]  semitone_a_o,
  output logic [4:0]  semitone_b_o,
  output logic        is_running_o
);
  import csq_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t result, out_q;
  logic      out_valid_q;
  logic      accept, load;

  assign cfg_ready_o = 1'b1;

  csq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  csq_core #(
    .StepCount (STEP_COUNT)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (load),
    .cfg_i     (cfg),
    .item_i    (in_q),
    .result_o  (result)
  );

  // result register takes a new item when empty or being drained
  assign load       = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~load;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.toggle_level <= toggle_level_i;
      in_q.start_level  <= start_level_i;
      in_q.stop_level   <= stop_level_i;
      in_q.skip_level   <= skip_level_i;
      in_q.reset_level  <= reset_level_i;
      in_q.phase_step   <= phase_step_i;
      in_q.pulse_width  <= pulse_width_i;
      in_q.random_step  <= random_step_i;
    end
    if (load) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign gate_buses_o       = out_q.gate_buses;
  assign clocked_gate_one_o = out_q.clocked_gate_one;
  assign clock_out_o        = out_q.clock_out;
  assign first_step_o       = out_q.first_step;
  assign step_a_o           = out_q.step_a;
  assign step_b_o           = out_q.step_b;
  assign level_a_o          = out_q.level_a;
  assign level_b_o          = out_q.level_b;
  assign semitone_a_o       = out_q.semitone_a;
  assign semitone_b_o       = out_q.semitone_b;
  assign is_running_o       = out_q.is_running;

endmodule

[sv/csq_checker.sv]
`timescale 1ns / 1ps

module csq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] gate_buses_o,
  input logic       clocked_gate_one_o,
  input logic       clock_out_o,
  input logic [3:0] step_a_o,
  input logic [7:0] level_a_o,
  input logic       is_running_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_a_o) && $stable(level_a_o))
    else $error("stalled result changed");

  // each step drives exactly one bus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(gate_buses_o))
    else $error("gate buses not one-hot");

  // no clock while stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clock_out_o |-> is_running_o)
    else $error("clock high while stopped");

  // clocked gate only on bus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clocked_gate_one_o |-> gate_buses_o[0])
    else $error("clocked gate without bus one");

endmodule

bind clocked_step_sequencer csq_checker u_csq_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import csq_pkg::*;

  localparam int unsigned StepCount     = StepCountDefault;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned TicksPerPhase = 75;
  localparam int unsigned PhaseCount    = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  in_item_t    tick_on_port = '0;

  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  gate_buses_o;
  logic        clocked_gate_one_o;
  logic        clock_out_o;
  logic        first_step_o;
  logic [3:0]  step_a_o;
  logic [3:0]  step_b_o;
  logic [7:0]  level_a_o;
  logic [7:0]  level_b_o;
  logic [4:0]  semitone_a_o;
  logic [4:0]  semitone_b_o;
  logic        is_running_o;

  clocked_step_sequencer u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .toggle_level_i     (tick_on_port.toggle_level),
    .start_level_i      (tick_on_port.start_level),
    .stop_level_i       (tick_on_port.stop_level),
    .skip_level_i       (tick_on_port.skip_level),
    .reset_level_i      (tick_on_port.reset_level),
    .phase_step_i       (tick_on_port.phase_step),
    .pulse_width_i      (tick_on_port.pulse_width),
    .random_step_i      (tick_on_port.random_step),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .gate_buses_o       (gate_buses_o),
    .clocked_gate_one_o (clocked_gate_one_o),
    .clock_out_o        (clock_out_o),
    .first_step_o       (first_step_o),
    .step_a_o           (step_a_o),
    .step_b_o           (step_b_o),
    .level_a_o          (level_a_o),
    .level_b_o          (level_b_o),
    .semitone_a_o       (semitone_a_o),
    .semitone_b_o       (semitone_b_o),
    .is_running_o       (is_running_o)
  );

  // sequencer copy kept alongside the block
  cfg_t        seq_cfg = '{start_gate_mode: 1'b0, bus_three_action: BusThreeNone,
                           dual_eight_mode: 1'b0, random_order: 1'b0,
                           gate_assign: 32'h5555_5555,
                           step_levels_low: 64'h7878_7878_7878_7878,
                           step_levels_high: 64'h7878_7878_7878_7878};
  logic        seq_run   = 1'b1;
  logic [31:0] seq_phase = '0;
  logic [3:0]  seq_step  = '0;
  logic        seq_held  = 1'b1;
  logic [4:0]  seq_hist  = 5'h1f;

  in_item_t    pending_ticks[$];
  out_item_t   expected_ticks[$];
  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatches     = 0;
  logic        in_taken       = 1'b0;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pct_toggle     = 4;
  int unsigned pct_start      = 6;
  int unsigned pct_stop       = 3;
  int unsigned pct_skip       = 10;
  int unsigned pct_reset      = 4;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void step_forward(logic [3:0] rnd);
    if (seq_cfg.random_order) begin
      seq_step = 4'(int'(rnd) % StepCount);
    end else begin
      seq_step = 4'((int'(seq_step) + 1) % StepCount);
    end
  endfunction

  function automatic logic [7:0] step_level(logic [3:0] s);
    logic [63:0] word;
    logic [7:0]  v;
    word = s[3] ? seq_cfg.step_levels_high : seq_cfg.step_levels_low;
    v = word[s[2:0]*8 +: 8];
    return (v > LevelMax) ? LevelMax : v;
  endfunction

  function automatic out_item_t sequencer_tick(in_item_t t);
    logic [4:0]  hist;
    logic [32:0] sum;
    logic        clk_bit;
    logic [3:0]  ia;
    logic [3:0]  ib;
    logic [1:0]  sw;
    bus_e        bus;
    logic [7:0]  la;
    logic [7:0]  lb;
    out_item_t   r;
    hist = seq_hist;
    clk_bit = 1'b0;
    if (seq_cfg.start_gate_mode) begin
      // levels decide directly, edge history left alone
      if (t.stop_level) seq_run = 1'b0;
      else seq_run = t.toggle_level | t.start_level;
    end else begin
      if (t.toggle_level && !hist[0]) seq_run = ~seq_run;
      if (t.start_level && !hist[1]) seq_run = 1'b1;
      if (t.stop_level && !hist[2]) seq_run = 1'b0;
      hist[2:0] = {t.stop_level, t.start_level, t.toggle_level};
    end
    if (seq_run) begin
      sum = {1'b0, seq_phase} + {1'b0, t.phase_step};
      if (sum[32]) begin
        step_forward(t.random_step);
        seq_phase = '0;
      end else begin
        seq_phase = sum[31:0];
      end
      seq_held = ({1'b0, seq_phase} < {t.pulse_width, 16'h0});
      clk_bit = seq_held;
    end
    if (seq_cfg.dual_eight_mode) begin
      ia = {1'b0, seq_step[2:0]};
      ib = ia + 4'd8;
    end else begin
      ia = seq_step;
      ib = seq_step;
    end
    sw = seq_cfg.gate_assign[ia*2 +: 2];
    if (sw == 2'd3) sw = 2'd2;
    bus = bus_e'(2'd2 - sw);
    if (t.skip_level && !hist[3]) step_forward(t.random_step);
    if (seq_cfg.bus_three_action == BusThreeSkip && bus == BUS_THREE) begin
      step_forward(t.random_step);
    end
    if (t.reset_level && !hist[4]) seq_step = '0;
    if (seq_cfg.bus_three_action == BusThreeReset && bus == BUS_THREE) seq_step = '0;
    hist[4:3] = {t.reset_level, t.skip_level};
    seq_hist = hist;
    la = step_level(ia);
    lb = step_level(ib);
    r.gate_buses = 3'b001 << bus;
    r.clocked_gate_one = (bus == BUS_ONE) && seq_held;
    r.clock_out = clk_bit;
    r.first_step = (ia == 4'd0);
    r.step_a = ia;
    r.step_b = ib;
    r.level_a = la;
    r.level_b = lb;
    r.semitone_a = 5'(la / 8'd10);
    r.semitone_b = 5'(lb / 8'd10);
    r.is_running = seq_run;
    return r;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [63:0] data);
    case (cfg_idx_e'(idx))
      CFG_START_GATE:  seq_cfg.start_gate_mode = data[0];
      CFG_BUS_THREE:   seq_cfg.bus_three_action = data[1:0];
      CFG_DUAL_EIGHT:  seq_cfg.dual_eight_mode = data[0];
      CFG_RANDOM:      seq_cfg.random_order = data[0];
      CFG_GATE_ASSIGN: seq_cfg.gate_assign = data[31:0];
      CFG_LEVELS_LO:   seq_cfg.step_levels_low = data;
      CFG_LEVELS_HI:   seq_cfg.step_levels_high = data;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // request driver and receiver stall
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        tick_on_port <= pending_ticks.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    logic      busy;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      busy = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        apply_cfg(cfg_index_i, cfg_data_i);
        busy = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        if (expected_ticks.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("gate_buses", want.gate_buses, gate_buses_o);
          check_field("clocked_gate_one", want.clocked_gate_one, clocked_gate_one_o);
          check_field("clock_out", want.clock_out, clock_out_o);
          check_field("first_step", want.first_step, first_step_o);
          check_field("step_a", want.step_a, step_a_o);
          check_field("step_b", want.step_b, step_b_o);
          check_field("level_a", want.level_a, level_a_o);
          check_field("level_b", want.level_b, level_b_o);
          check_field("semitone_a", want.semitone_a, semitone_a_o);
          check_field("semitone_b", want.semitone_b, semitone_b_o);
          check_field("is_running", want.is_running, is_running_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_ticks.push_back(sequencer_tick(tick_on_port));
        accepted_count++;
        busy = 1'b1;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    @(negedge clk_i);
    while (quiet_cycles < QuietLimit) @(negedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_tick(in_item_t t);
    pending_ticks.push_back(t);
    pushed_count++;
  endtask

  // wait until every request is in and every result is out, then let the pipe settle
  task automatic drain();
    while (accepted_count != pushed_count || expected_ticks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned n;
    in_item_t    t;
    logic        gate;
    logic [1:0]  b3;
    logic        dual;
    logic        rnd;
    logic [31:0] assign_bits;
    logic [63:0] lo;
    logic [63:0] hi;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks with the reset settings
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'h0, 17'h0, 4'h0});
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'hffff_ffff, 17'd65536, 4'hf});
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'hffff_ffff, 17'd65536, 4'h0});
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'h8000_0000, 17'd32768, 4'h5});
    // sum lands exactly on one
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'h8000_0000, 17'd32768, 4'ha});
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'h4000_0000, 17'd32768, 4'h3});
    // toggle edge stops, phase then frozen
    push_tick(in_item_t'{1, 0, 0, 0, 0, 32'h4000_0000, 17'd16384, 4'h3});
    push_tick(in_item_t'{1, 0, 0, 0, 0, 32'h4000_0000, 17'd65535, 4'h3});
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'hc000_0000, 17'd1, 4'h3});
    push_tick(in_item_t'{1, 0, 0, 0, 0, 32'h4000_0000, 17'd49152, 4'h7});
    push_tick(in_item_t'{0, 0, 1, 0, 0, 32'h4000_0000, 17'd49152, 4'h7});
    push_tick(in_item_t'{0, 1, 1, 0, 0, 32'h4000_0000, 17'd49152, 4'h7});
    push_tick(in_item_t'{0, 1, 0, 0, 0, 32'h7fff_ffff, 17'd0, 4'h9});
    push_tick(in_item_t'{0, 0, 0, 1, 0, 32'h1, 17'd65536, 4'h9});
    push_tick(in_item_t'{0, 0, 0, 1, 0, 32'h1, 17'd65536, 4'h9});
    push_tick(in_item_t'{0, 0, 0, 0, 1, 32'h0, 17'd2, 4'h0});
    push_tick(in_item_t'{0, 0, 0, 1, 1, 32'h0, 17'd2, 4'h0});
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'hffff_ffff, 17'h1ffff, 4'hf});
    push_tick(in_item_t'{1, 1, 1, 1, 1, 32'hffff_ffff, 17'h1ffff, 4'hf});
    push_tick(in_item_t'{0, 1, 0, 0, 0, 32'haaaa_5555, 17'h0aaaa, 4'h6});
    push_tick(in_item_t'{0, 0, 0, 0, 0, 32'h5555_aaaa, 17'h15555, 4'h9});

    for (p = 0; p < PhaseCount; p++) begin
      drain();
      assign_bits = $urandom;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case (p)
        0: begin
          gate = 1'b0; b3 = BusThreeReset; dual = 1'b0; rnd = 1'b0;
        end
        1: begin
          // every step on bus three, every level saturating
          gate = 1'b0; b3 = BusThreeSkip; dual = 1'b1; rnd = 1'b0;
          assign_bits = '0; lo = '1; hi = '1;
        end
        2: begin
          // unused bus three action, switch value three everywhere
          gate = 1'b1; b3 = 2'd3; dual = 1'b0; rnd = 1'b1;
          assign_bits = '1; lo = '0; hi = 64'hf1f0_ef00_0a09_ff01;
        end
        3: begin
          gate = 1'b1; b3 = BusThreeSkip; dual = 1'b1; rnd = 1'b1;
        end
        4: begin
          gate = 1'b0; b3 = BusThreeNone; dual = 1'b0; rnd = 1'b1;
        end
        5: begin
          gate = 1'b0; b3 = BusThreeReset; dual = 1'b1; rnd = 1'b0;
        end
        6: begin
          gate = 1'b1; b3 = BusThreeNone; dual = 1'b0; rnd = 1'b0;
        end
        default: begin
          gate = 1'($urandom_range(1)); b3 = 2'($urandom_range(3));
          dual = 1'($urandom_range(1)); rnd = 1'($urandom_range(1));
        end
      endcase
      write_reg(CFG_START_GATE, {63'h0, gate});
      write_reg(CFG_BUS_THREE, {62'h0, b3});
      write_reg(CFG_DUAL_EIGHT, {63'h0, dual});
      write_reg(CFG_RANDOM, {63'h0, rnd});
      write_reg(CFG_GATE_ASSIGN, {32'h0, assign_bits});
      write_reg(CFG_LEVELS_LO, lo);
      write_reg(CFG_LEVELS_HI, hi);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;

      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 70; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 70; end
        default: begin send_gap_pct = 24; recv_stall_pct = 24; end
      endcase
      // in gate mode the levels must mostly hold run high to get anywhere
      if (gate) begin
        pct_toggle = 20; pct_start = 75; pct_stop = 8;
      end else begin
        pct_toggle = 4; pct_start = 6; pct_stop = 3;
      end

      for (n = 0; n < TicksPerPhase; n++) begin
        t.toggle_level = ($urandom_range(99) < pct_toggle);
        t.start_level  = ($urandom_range(99) < pct_start);
        t.stop_level   = ($urandom_range(99) < pct_stop);
        t.skip_level   = ($urandom_range(99) < pct_skip);
        t.reset_level  = ($urandom_range(99) < pct_reset);
        case ($urandom_range(5))
          0: t.phase_step = $urandom;
          1: t.phase_step = 32'h8000_0000 + 32'($urandom_range(65535));
          2: t.phase_step = $urandom >> 3;
          3: t.phase_step = 32'hffff_ffff;
          4: t.phase_step = '0;
          default: t.phase_step = $urandom >> $urandom_range(1, 8);
        endcase
        case ($urandom_range(7))
          0: t.pulse_width = '0;
          1: t.pulse_width = 17'd65536;
          2: t.pulse_width = 17'($urandom_range(131071));
          default: t.pulse_width = 17'($urandom_range(65535));
        endcase
        t.random_step = 4'($urandom_range(15));
        push_tick(t);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[clocked_step_sequencer.f]
sv/csq_pkg.sv
sv/csq_cfg.sv
sv/csq_core.sv
sv/clocked_step_sequencer.sv
sv/csq_checker.sv
test/testbench.sv
